// ===== src/rwhp_pkg.sv =====
// ----------------------------------------------------------------------------
// rwhp_pkg
// Shared types and constants for the RIFF/WAVE header parser.
// ----------------------------------------------------------------------------
package rwhp_pkg;

  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;

  localparam logic [1:0] KIND_HEADER  = 2'd0;
  localparam logic [1:0] KIND_PAYLOAD = 2'd1;
  localparam logic [1:0] KIND_ERROR   = 2'd2;

  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_MAGIC    = 3'd1;
  localparam logic [2:0] ERR_NOT_PCM  = 3'd2;
  localparam logic [2:0] ERR_CHAN_RATE = 3'd3;
  localparam logic [2:0] ERR_NO_DATA  = 3'd4;

  localparam logic [15:0] FMT_PCM     = 16'd1;
  localparam logic [31:0] FMT_HDR_LEN = 32'd16;

  typedef enum logic [2:0] {
    PH_RIFF,
    PH_CHDR,
    PH_FMT,
    PH_SKIP,
    PH_PAY,
    PH_DONE,
    PH_ERR
  } phase_e;

  typedef struct packed {
    logic [7:0] stream_byte;
    logic       end_of_stream;
  } in_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [15:0] channel_count;
    logic [31:0] sample_rate;
    logic [15:0] sample_bits;
    logic [31:0] payload_offset;
    logic [31:0] payload_length;
    logic [7:0]  payload_byte;
    logic        last_payload;
    logic [2:0]  error_code;
  } out_t;

  // Queue status seen by the front and back parts.
  typedef struct packed {
    logic not_empty;
    logic full;
  } q_stat_t;

endpackage

// ===== src/rwhp_front.sv =====
// ----------------------------------------------------------------------------
// rwhp_front
// Byte parser: walks the RIFF header and chunks, builds result items.
// ----------------------------------------------------------------------------
module rwhp_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            take_i,
  input  rwhp_pkg::in_t   in_data_i,
  output logic            emit_o,
  output rwhp_pkg::out_t  res_o
);
  import rwhp_pkg::*;

  phase_e      phase_q, phase_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [31:0] shift_q, shift_d;
  logic [31:0] tag_q, tag_d;
  logic [31:0] len_q, len_d;
  logic [31:0] skip_q, skip_d;
  logic [15:0] fmt_q, fmt_d;
  logic [15:0] chan_q, chan_d;
  logic [31:0] rate_q, rate_d;
  logic [15:0] bits_q, bits_d;
  logic [31:0] pos_q, pos_d;
  logic [31:0] rem_q, rem_d;

  logic [31:0] shift_n;
  logic [4:0]  cnt_n;
  logic [31:0] skip_n;
  logic [31:0] rem_n;

  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    shift_d = shift_q;
    tag_d   = tag_q;
    len_d   = len_q;
    skip_d  = skip_q;
    fmt_d   = fmt_q;
    chan_d  = chan_q;
    rate_d  = rate_q;
    bits_d  = bits_q;
    rem_d   = rem_q;
    pos_d   = pos_q + 32'd1;
    emit_o  = 1'b0;
    res_o   = '0;

    shift_n = {in_data_i.stream_byte, shift_q[31:8]};
    cnt_n   = cnt_q + 5'd1;
    skip_n  = skip_q - 32'd1;
    rem_n   = rem_q - 32'd1;

    case (phase_q)
      PH_RIFF: begin
        shift_d = shift_n;
        cnt_d   = cnt_n;
        if (cnt_n == 5'd4) tag_d = shift_n;
        if (cnt_n == 5'd12) begin
          cnt_d = '0;
          if (tag_q != TAG_RIFF || shift_n != TAG_WAVE) begin
            emit_o           = 1'b1;
            res_o.result_kind = KIND_ERROR;
            res_o.error_code = ERR_MAGIC;
            phase_d          = PH_ERR;
          end else begin
            phase_d = PH_CHDR;
          end
        end
      end
      PH_CHDR: begin
        shift_d = shift_n;
        cnt_d   = cnt_n;
        if (cnt_n == 5'd4) tag_d = shift_n;
        if (cnt_n == 5'd8) begin
          cnt_d = '0;
          len_d = shift_n;
          if (tag_q == TAG_FMT) begin
            phase_d = PH_FMT;
          end else if (tag_q == TAG_DATA) begin
            emit_o = 1'b1;
            if (shift_n == '0) begin
              res_o.result_kind = KIND_ERROR;
              res_o.error_code  = ERR_NO_DATA;
              phase_d           = PH_ERR;
            end else begin
              res_o.result_kind    = KIND_HEADER;
              res_o.channel_count  = chan_q;
              res_o.sample_rate    = rate_q;
              res_o.sample_bits    = bits_q;
              res_o.payload_offset = pos_d;
              res_o.payload_length = shift_n;
              rem_d                = shift_n;
              phase_d              = PH_PAY;
            end
          end else begin
            skip_d  = shift_n;
            phase_d = (shift_n != '0) ? PH_SKIP : PH_CHDR;
          end
        end
      end
      PH_FMT: begin
        shift_d = shift_n;
        cnt_d   = cnt_n;
        if (cnt_n == 5'd4) begin
          fmt_d  = shift_n[15:0];
          chan_d = shift_n[31:16];
        end else if (cnt_n == 5'd8) begin
          rate_d = shift_n;
        end else if (cnt_n == 5'd16) begin
          bits_d = shift_n[31:16];
          cnt_d  = '0;
          if (fmt_q != FMT_PCM) begin
            emit_o            = 1'b1;
            res_o.result_kind = KIND_ERROR;
            res_o.error_code  = ERR_NOT_PCM;
            phase_d           = PH_ERR;
          end else if (chan_q == '0 || rate_q == '0) begin
            emit_o            = 1'b1;
            res_o.result_kind = KIND_ERROR;
            res_o.error_code  = ERR_CHAN_RATE;
            phase_d           = PH_ERR;
          end else if (len_q > FMT_HDR_LEN) begin
            skip_d  = len_q - FMT_HDR_LEN;
            phase_d = PH_SKIP;
          end else begin
            phase_d = PH_CHDR;
          end
        end
      end
      PH_SKIP: begin
        skip_d = skip_n;
        if (skip_n == '0) phase_d = PH_CHDR;
      end
      PH_PAY: begin
        rem_d              = rem_n;
        emit_o             = 1'b1;
        res_o.result_kind  = KIND_PAYLOAD;
        res_o.payload_byte = in_data_i.stream_byte;
        res_o.last_payload = (rem_n == '0);
        if (rem_n == '0) phase_d = PH_DONE;
      end
      default: begin
      end
    endcase

    // End of stream: flag a missing data chunk, then start over.
    if (in_data_i.end_of_stream) begin
      if (!emit_o && (phase_d == PH_RIFF || phase_d == PH_CHDR ||
                      phase_d == PH_FMT || phase_d == PH_SKIP)) begin
        emit_o            = 1'b1;
        res_o             = '0;
        res_o.result_kind = KIND_ERROR;
        res_o.error_code  = ERR_NO_DATA;
      end
      phase_d = PH_RIFF;
      cnt_d   = '0;
      shift_d = '0;
      tag_d   = '0;
      len_d   = '0;
      skip_d  = '0;
      fmt_d   = '0;
      chan_d  = '0;
      rate_d  = '0;
      bits_d  = '0;
      pos_d   = '0;
      rem_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_RIFF;
      cnt_q   <= '0;
      shift_q <= '0;
      tag_q   <= '0;
      len_q   <= '0;
      skip_q  <= '0;
      fmt_q   <= '0;
      chan_q  <= '0;
      rate_q  <= '0;
      bits_q  <= '0;
      pos_q   <= '0;
      rem_q   <= '0;
    end else if (take_i) begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      shift_q <= shift_d;
      tag_q   <= tag_d;
      len_q   <= len_d;
      skip_q  <= skip_d;
      fmt_q   <= fmt_d;
      chan_q  <= chan_d;
      rate_q  <= rate_d;
      bits_q  <= bits_d;
      pos_q   <= pos_d;
      rem_q   <= rem_d;
    end
  end

endmodule

// ===== src/rwhp_queue.sv =====
// ----------------------------------------------------------------------------
// rwhp_queue
// Two-entry result queue between the parser and the output stage.
// ----------------------------------------------------------------------------
module rwhp_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  rwhp_pkg::out_t    push_data_i,
  input  logic              pop_i,
  output rwhp_pkg::out_t    pop_data_o,
  output rwhp_pkg::q_stat_t stat_o
);
  import rwhp_pkg::*;

  out_t       mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push_i;
    rd_ptr_d = rd_ptr_q ^ pop_i;
    count_d  = count_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  assign pop_data_o       = mem_q[rd_ptr_q];
  assign stat_o.not_empty = (count_q != 2'd0);
  assign stat_o.full      = (count_q == 2'd2);

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

// ===== src/rwhp_back.sv =====
// ----------------------------------------------------------------------------
// rwhp_back
// Output stage: pulls queued results into the output register.
// ----------------------------------------------------------------------------
module rwhp_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rwhp_pkg::q_stat_t stat_i,
  input  rwhp_pkg::out_t    q_data_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output rwhp_pkg::out_t    out_data_o
);
  import rwhp_pkg::*;

  logic valid_q, valid_d;
  out_t data_q;

  // Load when the register is empty or its transfer completes now.
  assign pop_o   = stat_i.not_empty && (!valid_q || out_ready_i);
  assign valid_d = pop_o || (valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) data_q <= q_data_i;
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

// ===== src/riff_wave_header_parser.sv =====
// A result passes through the result queue and then the output register on its way out.
// Throughput: one byte per cycle while the result queue has room; each byte gives at most one result.
// The input stalls only when the two-entry result queue is full.
// Reset: rst_ni is asynchronous and active low; it returns the parser to the
// RIFF header phase and empties the queue and the output register.
// ----------------------------------------------------------------------------
// riff_wave_header_parser
// Byte-wide WAV parser: checks RIFF/WAVE, reads fmt, forwards data bytes.
// ----------------------------------------------------------------------------
module riff_wave_header_parser (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  rwhp_pkg::in_t   in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output rwhp_pkg::out_t  out_data_o
);
  import rwhp_pkg::*;

  logic    take;
  logic    emit;
  out_t    res;
  out_t    q_data;
  q_stat_t q_stat;
  logic    pop;

  // Front side: accept a byte whenever the queue has room for its result.
  assign in_ready_o = !q_stat.full;
  assign take       = in_valid_i && in_ready_o;

  rwhp_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .take_i    (take),
    .in_data_i (in_data_i),
    .emit_o    (emit),
    .res_o     (res)
  );

  // Queue: hold finished results so parsing never waits on the consumer
  // while there is space.
  rwhp_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (take && emit),
    .push_data_i (res),
    .pop_i       (pop),
    .pop_data_o  (q_data),
    .stat_o      (q_stat)
  );

  // Back side: advance results to the output register, one transfer a cycle while out_ready_i is high.
  rwhp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .stat_i      (q_stat),
    .q_data_i    (q_data),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== src/rwhp_checker.sv =====
// ----------------------------------------------------------------------------
// rwhp_checker
// Port-level checks for the WAV parser, bound to the top level.
// ----------------------------------------------------------------------------
module rwhp_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           out_valid_o,
  input logic           out_ready_i,
  input rwhp_pkg::out_t out_data_o
);
  import rwhp_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output dropped before transfer");

  a_kind_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.result_kind == KIND_HEADER ||
      out_data_o.result_kind == KIND_PAYLOAD || out_data_o.result_kind == KIND_ERROR)
    else $error("illegal result kind");

  a_error_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.result_kind == KIND_ERROR |->
      out_data_o.error_code == ERR_MAGIC || out_data_o.error_code == ERR_NOT_PCM ||
      out_data_o.error_code == ERR_CHAN_RATE || out_data_o.error_code == ERR_NO_DATA)
    else $error("error result without a valid code");

  a_header_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.result_kind == KIND_HEADER |->
      out_data_o.payload_length != '0 && out_data_o.error_code == ERR_NONE)
    else $error("header info with zero data length");

  a_payload_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.result_kind == KIND_PAYLOAD |->
      out_data_o.error_code == ERR_NONE && out_data_o.payload_length == '0)
    else $error("payload byte carries header or error fields");

endmodule

bind riff_wave_header_parser rwhp_checker u_rwhp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
